@@ src/ggc_pkg.sv @@
// ----------------------------------------------------------------------------
// ggc_pkg: shared types, constants and elaboration functions
// Formats, register indexes, reset values and the CORDIC angle and gain
// tables used by the go-to-goal controller.
// ----------------------------------------------------------------------------
package ggc_pkg;

    // Micro-rotation count default
    localparam int GGC_CORDIC_STEPS_DEF = 16;

    // Datapath widths
    localparam int X_W = 36;   // CORDIC x and y, Q16.16 plus growth
    localparam int Z_W = 32;   // angle with 28 fraction bits
    localparam int W_W = 34;   // heading error with 28 fraction bits
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Angle constants, 28 fraction bits
    localparam logic signed [Z_W-1:0] ANG_PI     = 32'sd843314857;
    localparam logic signed [Z_W-1:0] ANG_TWO_PI = 32'sd1686629713;
    localparam logic signed [Z_W-1:0] ANG_PI_4   = 32'sd210828714;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_DISTANCE   = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_LINEAR_GAIN       = 16'd819;
    localparam logic [15:0] RST_HEADING_GAIN      = 16'd1065;
    localparam logic [14:0] RST_MAX_LINEAR_SPEED  = 15'd2867;
    localparam logic [14:0] RST_MAX_ANGULAR_SPEED = 15'd2458;
    localparam logic [30:0] RST_ARRIVE_DISTANCE   = 31'd3277;

    // Vector handed from cell to cell
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic signed [15:0]    heading;
    } ggc_vec_t;

    // Configuration seen by the post-processing stages
    typedef struct packed {
        logic [15:0] linear_gain;
        logic [15:0] heading_gain;
        logic [14:0] max_linear_speed;
        logic [14:0] max_angular_speed;
        logic [30:0] arrive_distance;
    } ggc_cfg_t;

    // One result item
    typedef struct packed {
        logic [14:0]        linear_velocity;
        logic signed [15:0] angular_velocity;
        logic               arrived;
    } ggc_result_t;

    // Restoring unsigned division, elaboration only
    function automatic logic [63:0] ggc_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Integer square root, elaboration only
    function automatic logic [63:0] ggc_isqrt(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v  = val;
        r  = '0;
        bt = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (v >= r + bt)
            begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end
            else
            begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // atan(2^-step) with 28 fraction bits, from its power series
    function automatic logic signed [31:0] ggc_atan(input int unsigned step);
        logic signed [63:0] sum;
        logic signed [63:0] rnd;
        logic [63:0]        term;
        int unsigned        n;
        sum = '0;
        for (int unsigned k = 0; k < 64; k++)
        begin
            n = 2 * k + 1;
            if (step * n <= 62)
            begin
                term = ggc_udiv(64'd1 << (62 - step * n), 64'(n));
                if (k[0])
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
        end
        rnd = (sum + (64'sd1 <<< 33)) >>> 34;
        if (step == 0)
            return ANG_PI_4;
        return rnd[31:0];
    endfunction

    // Inverse CORDIC gain with 28 fraction bits
    function automatic logic [63:0] ggc_inv_gain(input int unsigned steps);
        logic [63:0] k2;
        logic [63:0] kq;
        k2 = 64'd1 << 30;
        for (int unsigned i = 0; i < steps; i++)
            k2 = k2 + (k2 >> (2 * i));
        kq = ggc_isqrt(k2 << 30);
        return ggc_udiv((64'd1 << 58) + (kq >> 1), kq);
    endfunction

endpackage

@@ src/ggc_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// ggc_cordic_cell: one vectoring micro-rotation
// Rotates the vector toward the x axis by atan(2^-STEP), accumulates the
// angle and hands the registered result to the next cell.
// ----------------------------------------------------------------------------
module ggc_cordic_cell
    import ggc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  ggc_vec_t in_vec,
    output logic     out_valid,
    output ggc_vec_t out_vec
);

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(ggc_atan(STEP));

    logic signed [X_W-1:0] x_cur;
    logic signed [X_W-1:0] y_cur;
    logic signed [X_W-1:0] x_sh;
    logic signed [X_W-1:0] y_sh;
    logic                  valid_reg;
    ggc_vec_t              vec_reg;
    ggc_vec_t              vec_next;

    // Rotate toward the x axis, direction from the sign of y
    always_comb
    begin
        x_cur = in_vec.x;
        y_cur = in_vec.y;
        x_sh  = x_cur >>> STEP;
        y_sh  = y_cur >>> STEP;
        vec_next.heading = in_vec.heading;
        if (!y_cur[X_W-1])
        begin
            vec_next.x = x_cur + y_sh;
            vec_next.y = y_cur - x_sh;
            vec_next.z = in_vec.z + ATAN;
        end
        else
        begin
            vec_next.x = x_cur - y_sh;
            vec_next.y = y_cur + x_sh;
            vec_next.z = in_vec.z - ATAN;
        end
    end

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

@@ src/ggc_post.sv @@
// ----------------------------------------------------------------------------
// ggc_post: distance scaling, heading error and velocity laws
// Six registered stages after the CORDIC chain: gain correction of the
// distance, bearing wrap, arrival test and the two clamped products.
// ----------------------------------------------------------------------------
module ggc_post
    import ggc_pkg::*;
#(
    parameter int CORDIC_STEPS = GGC_CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  ggc_vec_t    in_vec,
    input  ggc_cfg_t    cfg,
    output logic        out_valid,
    output ggc_result_t out_res
);

    localparam logic [63:0] INV_GAIN_FULL = ggc_inv_gain(CORDIC_STEPS);
    localparam logic [27:0] INV_GAIN      = INV_GAIN_FULL[27:0];
    localparam int          NSTG          = 6;

    logic [NSTG-1:0] valid_reg;

    // Stage 1
    logic [45:0]           s1_plo_reg;
    logic [44:0]           s1_phi_reg;
    logic signed [Z_W-1:0] s1_z_reg;
    logic signed [15:0]    s1_heading_reg;
    // Stage 2
    logic [33:0]           s2_dist_reg;
    logic signed [W_W-1:0] s2_w_reg;
    // Stage 3
    logic                  s3_arrived_reg;
    logic [31:0]           s3_dist_reg;
    logic signed [W_W-1:0] s3_w_reg;
    // Stage 4
    logic                  s4_arrived_reg;
    logic [47:0]           s4_lin_prod_reg;
    logic                  s4_neg_reg;
    logic [31:0]           s4_mag_reg;
    // Stage 5
    logic                  s5_arrived_reg;
    logic [14:0]           s5_lin_reg;
    logic                  s5_neg_reg;
    logic [47:0]           s5_ang_prod_reg;
    // Stage 6
    ggc_result_t           s6_res_reg;

    logic [34:0]           x_mag;
    logic [61:0]           dist_sum;
    logic signed [W_W-1:0] w_wrap;
    logic [48:0]           lin_sum;
    logic [32:0]           lin_full;
    logic [48:0]           ang_sum;
    logic [20:0]           ang_full;
    logic [14:0]           ang_sat;
    ggc_result_t           res_next;

    assign x_mag    = in_vec.x[34:0];
    assign dist_sum = 62'(s1_plo_reg) + (62'(s1_phi_reg) << 18) + (62'd1 << 27);
    assign w_wrap   = (s2_w_reg > W_W'(ANG_PI)) ? s2_w_reg - W_W'(ANG_TWO_PI) : s2_w_reg;
    assign lin_sum  = 49'(s4_lin_prod_reg) + (49'd1 << 15);
    assign lin_full = lin_sum[48:16];
    assign ang_sum  = 49'(s5_ang_prod_reg) + (49'd1 << 27);
    assign ang_full = ang_sum[48:28];
    assign ang_sat  = (ang_full > 21'(cfg.max_angular_speed)) ? cfg.max_angular_speed
                                                              : ang_full[14:0];

    // Zero both speeds on arrival, sign the turn rate otherwise
    always_comb
    begin
        res_next.arrived = s5_arrived_reg;
        if (s5_arrived_reg)
        begin
            res_next.linear_velocity  = '0;
            res_next.angular_velocity = '0;
        end
        else
        begin
            res_next.linear_velocity  = s5_lin_reg;
            res_next.angular_velocity = s5_neg_reg ? -$signed({1'b0, ang_sat})
                                                   : $signed({1'b0, ang_sat});
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NSTG-2:0], in_valid};
    end

    // Advance payload through the stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // split distance product, map bearing into 0 to 2pi
            s1_plo_reg     <= 46'(x_mag[17:0]) * 46'(INV_GAIN);
            s1_phi_reg     <= 45'(x_mag[34:18]) * 45'(INV_GAIN);
            s1_z_reg       <= in_vec.z[Z_W-1] ? in_vec.z + ANG_TWO_PI : in_vec.z;
            s1_heading_reg <= in_vec.heading;
            // join partial products, subtract yaw
            s2_dist_reg    <= dist_sum[61:28];
            s2_w_reg       <= W_W'(s1_z_reg) - (W_W'(s1_heading_reg) <<< 15);
            // arrival test, saturate distance for the multiplier, wrap once
            s3_arrived_reg <= (s2_dist_reg <= 34'(cfg.arrive_distance));
            s3_dist_reg    <= (|s2_dist_reg[33:32]) ? 32'hFFFF_FFFF : s2_dist_reg[31:0];
            s3_w_reg       <= w_wrap;
            // linear product, error magnitude
            s4_arrived_reg  <= s3_arrived_reg;
            s4_lin_prod_reg <= 48'(s3_dist_reg) * 48'(cfg.linear_gain);
            s4_neg_reg      <= s3_w_reg[W_W-1];
            s4_mag_reg      <= s3_w_reg[W_W-1] ? 32'(-s3_w_reg) : 32'(s3_w_reg);
            // angular product, clamp linear speed
            s5_arrived_reg  <= s4_arrived_reg;
            s5_lin_reg      <= (lin_full > 33'(cfg.max_linear_speed)) ? cfg.max_linear_speed
                                                                      : lin_full[14:0];
            s5_neg_reg      <= s4_neg_reg;
            s5_ang_prod_reg <= 48'(s4_mag_reg) * 48'(cfg.heading_gain);
            // final result
            s6_res_reg      <= res_next;
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign out_res   = s6_res_reg;

endmodule

@@ src/ggc_skid.sv @@
// ----------------------------------------------------------------------------
// ggc_skid: output register with a hold stage
// Presents result items on the output channel and parks one more item
// while the consumer stalls, so the pipeline stops on a registered flag.
// ----------------------------------------------------------------------------
module ggc_skid
    import ggc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  ggc_result_t in_res,
    output logic        full,
    output logic        out_valid,
    input  logic        out_ready,
    output ggc_result_t out_res
);

    logic        main_valid_reg;
    logic        main_valid_next;
    ggc_result_t main_reg;
    ggc_result_t main_next;
    logic        hold_valid_reg;
    logic        hold_valid_next;
    ggc_result_t hold_reg;
    ggc_result_t hold_next;
    logic        take;

    assign take = in_valid && !hold_valid_reg;

    // Refill the output register from the hold stage first, else park
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (!main_valid_reg || out_ready)
        begin
            if (hold_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = hold_reg;
                hold_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = take;
                if (take)
                    main_next = in_res;
            end
        end
        else if (take)
        begin
            hold_valid_next = 1'b1;
            hold_next       = in_res;
        end
    end

    // Hold flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        hold_reg <= hold_next;
    end

    assign full      = hold_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

endmodule

@@ src/go_to_goal_controller_core.sv @@
// ----------------------------------------------------------------------------
// go_to_goal_controller_core: proportional go-to-goal velocity controller
// Distance and bearing to the goal from a pipelined CORDIC chain, then
// clamped proportional linear and angular speed commands.
// ----------------------------------------------------------------------------
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  in      | in_valid in_ready pos_x pos_y heading       | to block
//          | goal_x goal_y                               |
//  out     | out_valid out_ready linear_velocity         | from block
//          | angular_velocity arrived                    |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data      | to block
//
//  One item per cycle while in_ready is high. An item passes an input
//  register, one CORDIC cell per micro-rotation, six post stages and the
//  output register. Reset clears all valid bits and loads the default gains
//  and limits. A stalled output parks one item in a hold stage; in_ready
//  then drops.
// ----------------------------------------------------------------------------
module go_to_goal_controller_core
    import ggc_pkg::*;
#(
    parameter int CORDIC_STEPS = GGC_CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [15:0]    heading,
    input  logic signed [31:0]    goal_x,
    input  logic signed [31:0]    goal_y,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [14:0]           linear_velocity,
    output logic signed [15:0]    angular_velocity,
    output logic                  arrived,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ggc_cfg_t          cfg_reg;
    logic              adv;
    logic              hold_full;
    logic              pre_valid_reg;
    ggc_vec_t          pre_reg;
    ggc_vec_t          pre_next;
    logic signed [32:0] dx_fwd;
    logic signed [32:0] dx_rev;
    logic signed [32:0] dy_fwd;
    logic signed [32:0] dy_rev;
    logic              chain_valid [0:CORDIC_STEPS];
    ggc_vec_t          chain_vec   [0:CORDIC_STEPS];
    logic              post_valid;
    ggc_result_t       post_res;
    ggc_result_t       out_res;

    assign in_ready  = !hold_full;
    assign adv       = !hold_full;
    assign cfg_ready = 1'b1;

    // Write configuration registers, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear_gain       <= RST_LINEAR_GAIN;
            cfg_reg.heading_gain      <= RST_HEADING_GAIN;
            cfg_reg.max_linear_speed  <= RST_MAX_LINEAR_SPEED;
            cfg_reg.max_angular_speed <= RST_MAX_ANGULAR_SPEED;
            cfg_reg.arrive_distance   <= RST_ARRIVE_DISTANCE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LINEAR_GAIN:       cfg_reg.linear_gain       <= cfg_data[15:0];
                REG_HEADING_GAIN:      cfg_reg.heading_gain      <= cfg_data[15:0];
                REG_MAX_LINEAR_SPEED:  cfg_reg.max_linear_speed  <= cfg_data[14:0];
                REG_MAX_ANGULAR_SPEED: cfg_reg.max_angular_speed <= cfg_data[14:0];
                REG_ARRIVE_DISTANCE:   cfg_reg.arrive_distance   <= cfg_data[30:0];
                default:               ;
            endcase
        end
    end

    // Form the goal offset, folded into the right half plane
    assign dx_fwd = 33'(goal_x) - 33'(pos_x);
    assign dx_rev = 33'(pos_x) - 33'(goal_x);
    assign dy_fwd = 33'(goal_y) - 33'(pos_y);
    assign dy_rev = 33'(pos_y) - 33'(goal_y);

    always_comb
    begin
        pre_next.heading = heading;
        if (dx_fwd[32])
        begin
            pre_next.x = X_W'(dx_rev);
            pre_next.y = X_W'(dy_rev);
            pre_next.z = ANG_PI;
        end
        else
        begin
            pre_next.x = X_W'(dx_fwd);
            pre_next.y = X_W'(dy_fwd);
            pre_next.z = '0;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (adv)
            pre_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pre_reg <= pre_next;
    end

    assign chain_valid[0] = pre_valid_reg;
    assign chain_vec[0]   = pre_reg;

    // CORDIC cell chain
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        ggc_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .out_valid (chain_valid[i+1]),
            .out_vec   (chain_vec[i+1])
        );
    end

    // Distance, heading error and speed laws
    ggc_post #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_vec    (chain_vec[CORDIC_STEPS]),
        .cfg       (cfg_reg),
        .out_valid (post_valid),
        .out_res   (post_res)
    );

    // Output register and hold stage
    ggc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (post_valid),
        .in_res    (post_res),
        .full      (hold_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign linear_velocity  = out_res.linear_velocity;
    assign angular_velocity = out_res.angular_velocity;
    assign arrived          = out_res.arrived;

    // A parked item always sits behind a presented one
    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_full |-> out_valid)
        else $error("hold stage full while output register empty");

    // The hold stage fills only after a stalled output
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hold_full) |-> $past(out_valid && !out_ready))
        else $error("hold stage filled without an output stall");

    // Arrival forces zero speeds
    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && arrived) |-> (linear_velocity == '0 && angular_velocity == '0))
        else $error("arrived item carries nonzero speed");

endmodule
